>>> rtl/core/rpn_stack_calculator_assert.svh
// Assertion macros used by the checker file rpn_checker.sv.
// No dependencies.
`ifndef RPN_STACK_CALCULATOR_ASSERT_SVH
`define RPN_STACK_CALCULATOR_ASSERT_SVH
// implication check on a clock with async reset
`define RPN_ASSERT_IMP(lbl, clk, rstn, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |-> (post)) \
    else $error("assertion failed");
// next-cycle implication
`define RPN_ASSERT_NXT(lbl, clk, rstn, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) \
    else $error("assertion failed");
`endif

>>> rtl/core/rpn_pkg.sv
// Package for the RPN calculator: codes, types, helper functions.
// No dependencies.
`default_nettype none
package rpn_pkg;
  localparam int unsigned StackDepthDef = 16;
  localparam int unsigned DataW = 64;

  localparam logic [1:0] ModePush = 2'd0;
  localparam logic [1:0] ModeOp   = 2'd1;
  localparam logic [1:0] ModeFin  = 2'd2;

  localparam logic [4:0] OpAdd = 5'd0;
  localparam logic [4:0] OpSub = 5'd1;
  localparam logic [4:0] OpMul = 5'd2;
  localparam logic [4:0] OpDiv = 5'd3;
  localparam logic [4:0] OpMod = 5'd4;
  localparam logic [4:0] OpAnd = 5'd5;
  localparam logic [4:0] OpOr  = 5'd6;
  localparam logic [4:0] OpXor = 5'd7;
  localparam logic [4:0] OpNot = 5'd8;
  localparam logic [4:0] OpSw32 = 5'd9;
  localparam logic [4:0] OpSw16 = 5'd10;
  localparam logic [4:0] OpShr = 5'd11;
  localparam logic [4:0] OpShl = 5'd12;
  localparam logic [4:0] OpLt  = 5'd13;
  localparam logic [4:0] OpLe  = 5'd14;
  localparam logic [4:0] OpGt  = 5'd15;
  localparam logic [4:0] OpGe  = 5'd16;
  localparam logic [4:0] OpEq  = 5'd17;

  localparam logic [2:0] StOk    = 3'd0;
  localparam logic [2:0] StFull  = 3'd1;
  localparam logic [2:0] StFew   = 3'd2;
  localparam logic [2:0] StDiv0  = 3'd3;
  localparam logic [2:0] StEmpty = 3'd4;
  localparam logic [2:0] StMulti = 3'd5;

  // classified command kinds
  typedef enum logic [2:0] {
    KPush, KUnary, KBinary, KDivide, KFinish, KNop
  } kind_e;

  typedef struct packed {
    kind_e       kind;
    logic [4:0]  opcode;
    logic [63:0] value;
  } cmd_t;

  function automatic logic [63:0] unary_f(logic [4:0] op, logic [63:0] a);
    logic [63:0] r;
    r = '0;
    case (op)
      OpNot:   r = ~a;
      OpSw32:  r = {32'd0, a[7:0], a[15:8], a[23:16], a[31:24]};
      default: r = {48'd0, a[7:0], a[15:8]};
    endcase
    return r;
  endfunction
endpackage
`default_nettype wire

>>> rtl/core/rpn_front.sv
// Front end: accepts commands, classifies them, writes the command queue.
// Depends on rpn_pkg.
`default_nettype none
module rpn_front
  import rpn_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [1:0]  mode_i,
  input  wire logic [63:0] value_i,
  input  wire logic [4:0]  opcode_i,
  input  wire logic        pop_i,
  output logic             busy_o,
  output logic             avail_o,
  output cmd_t             cmd_o
);
  // two-entry queue
  cmd_t        q_q [2];
  logic        wp_q, rp_q;
  logic [1:0]  cnt_q;
  cmd_t        in_cmd;
  logic        push;

  always_comb begin
    in_cmd.value  = value_i;
    in_cmd.opcode = opcode_i;
    case (mode_i)
      ModePush: in_cmd.kind = KPush;
      ModeFin:  in_cmd.kind = KFinish;
      ModeOp: begin
        if (opcode_i > OpEq) in_cmd.kind = KNop;
        else if (opcode_i == OpDiv || opcode_i == OpMod) in_cmd.kind = KDivide;
        else if (opcode_i >= OpNot && opcode_i <= OpSw16) in_cmd.kind = KUnary;
        else in_cmd.kind = KBinary;
      end
      default:  in_cmd.kind = KNop;
    endcase
  end

  assign busy_o  = cnt_q[1];
  assign push    = start_i && !busy_o;
  assign avail_o = cnt_q != 2'd0;
  assign cmd_o   = q_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push) q_q[wp_q] <= in_cmd;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= 2'd0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (pop_i) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop_i};
    end
  end
endmodule
`default_nettype wire

>>> rtl/core/rpn_div.sv
// Iterative signed 64-bit divider, one quotient bit per cycle.
// Depends on rpn_pkg.
`default_nettype none
module rpn_div
  import rpn_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        go_i,
  input  wire logic [63:0] a_i,
  input  wire logic [63:0] b_i,
  input  wire logic        rem_i,
  output logic             done_o,
  output logic [63:0]      res_o
);
  logic [63:0] quo_q, rem_q, den_q;
  logic [6:0]  cnt_q;
  logic        run_q, neg_q, wrem_q;
  logic [64:0] trial;

  assign trial = {rem_q, quo_q[63]} - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0; done_o <= 1'b0; cnt_q <= '0;
    end else begin
      done_o <= 1'b0;
      if (go_i) begin
        run_q <= 1'b1; cnt_q <= 7'd0;
      end else if (run_q) begin
        cnt_q <= cnt_q + 7'd1;
        if (cnt_q == 7'd63) begin
          run_q <= 1'b0; done_o <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (go_i) begin
      quo_q  <= a_i[63] ? 64'd0 - a_i : a_i;
      den_q  <= b_i[63] ? 64'd0 - b_i : b_i;
      rem_q  <= '0;
      wrem_q <= rem_i;
      neg_q  <= rem_i ? a_i[63] : (a_i[63] ^ b_i[63]);
    end else if (run_q) begin
      if (!trial[64]) begin
        rem_q <= trial[63:0];
        quo_q <= {quo_q[62:0], 1'b1};
      end else begin
        rem_q <= {rem_q[62:0], quo_q[63]};
        quo_q <= {quo_q[62:0], 1'b0};
      end
    end
  end

  logic [63:0] mag;
  assign mag   = wrem_q ? rem_q : quo_q;
  assign res_o = neg_q ? 64'd0 - mag : mag;
endmodule
`default_nettype wire

>>> rtl/core/rpn_back.sv
// Back end: executes queued commands against the operand stack.
// Depends on rpn_pkg, rpn_div.
`default_nettype none
module rpn_back
  import rpn_pkg::*;
#(
  parameter int unsigned StackDepth = StackDepthDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        avail_i,
  input  cmd_t             cmd_i,
  input  wire logic        mask_i,
  output logic             pop_o,
  output logic             done_o,
  output logic [2:0]       status_o,
  output logic [63:0]      result_o,
  output logic [4:0]       depth_o
);
  localparam int unsigned AW = $clog2(StackDepth);
  localparam int unsigned DW = $clog2(StackDepth + 1);

  localparam logic [2:0] SIdle = 3'd0;
  localparam logic [2:0] SRead = 3'd1;
  localparam logic [2:0] SExec = 3'd2;
  localparam logic [2:0] SDivW = 3'd3;
  localparam logic [2:0] SMul  = 3'd4;

  logic [63:0] mem [StackDepth];
  logic [2:0]  st_q;
  logic [DW-1:0] dep_q;
  logic [2:0]  err_q;
  logic [63:0] top_q;      // cached top entry
  logic [63:0] nxt_q;      // unused; rd_q holds the entry below top (or bottom for finish)
  logic [63:0] rd_q;
  logic [AW-1:0] raddr;
  logic [63:0] mul_q;
  cmd_t        c_q;
  logic        dgo;
  logic        ddone;
  logic [63:0] dres;

  rpn_div u_div (
    .clk_i, .rst_ni, .go_i(dgo), .a_i(rd_q), .b_i(top_q),
    .rem_i(c_q.opcode == OpMod), .done_o(ddone), .res_o(dres)
  );

  // read address of the latched command: bottom for finish, entry below top otherwise
  always_comb begin
    raddr = '0;
    if (c_q.kind != KFinish && dep_q >= DW'(2)) raddr = AW'(dep_q - DW'(2));
  end

  always_ff @(posedge clk_i) begin
    rd_q <= mem[raddr];
  end

  logic [63:0] a, b, bres;
  logic [5:0]  sh;
  logic        slt, seq;
  assign a = rd_q;
  assign b = top_q;
  assign sh = b[5:0];
  assign slt = $signed(a) < $signed(b);
  assign seq = a == b;
  always_comb begin
    case (c_q.opcode)
      OpAdd:   bres = a + b;
      OpSub:   bres = a - b;
      OpAnd:   bres = a & b;
      OpOr:    bres = a | b;
      OpXor:   bres = a ^ b;
      OpShr:   bres = $unsigned($signed(a) >>> sh);
      OpShl:   bres = a << sh;
      OpLt:    bres = {63'd0, slt};
      OpLe:    bres = {63'd0, slt | seq};
      OpGt:    bres = {63'd0, !(slt | seq)};
      OpGe:    bres = {63'd0, !slt};
      default: bres = {63'd0, seq};
    endcase
  end

  // bottom entry for finish
  logic [63:0] fin_val;
  assign fin_val = (dep_q == DW'(1)) ? top_q : rd_q;

  logic fire;
  assign fire   = st_q == SIdle && avail_i;
  assign pop_o  = fire;
  assign dgo    = st_q == SExec && c_q.kind == KDivide && err_q == StOk
                  && dep_q >= DW'(2) && top_q != 64'd0;

  logic [63:0] wdat;
  logic        wen;
  logic [AW-1:0] waddr;

  always_ff @(posedge clk_i) begin
    if (wen) mem[waddr] <= wdat;
  end

  always_comb begin
    wen = 1'b0; waddr = '0; wdat = top_q;
    if (st_q == SExec && err_q == StOk && c_q.kind == KPush
        && dep_q < DW'(StackDepth)) begin
      wen = 1'b1; waddr = AW'(dep_q); wdat = c_q.value;
    end else if (st_q == SExec && err_q == StOk && c_q.kind == KUnary
                 && dep_q != '0) begin
      wen = 1'b1; waddr = AW'(dep_q - DW'(1)); wdat = unary_f(c_q.opcode, top_q);
    end else if (st_q == SExec && err_q == StOk && c_q.kind == KBinary
                 && dep_q >= DW'(2) && c_q.opcode != OpMul) begin
      wen = 1'b1; waddr = AW'(dep_q - DW'(2)); wdat = bres;
    end else if (st_q == SMul) begin
      wen = 1'b1; waddr = AW'(dep_q - DW'(2)); wdat = mul_q;
    end else if (st_q == SDivW && ddone) begin
      wen = 1'b1; waddr = AW'(dep_q - DW'(2)); wdat = dres;
    end
  end

  // 64x64 low product split into 32-bit partial products
  logic [63:0] pll, plh, phl;
  always_ff @(posedge clk_i) begin
    pll <= a[31:0] * b[31:0];
    plh <= {32'd0, a[31:0] * b[63:32]};
    phl <= {32'd0, a[63:32] * b[31:0]};
  end
  assign mul_q = pll + {plh[31:0] + phl[31:0], 32'd0};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= SIdle; dep_q <= '0; err_q <= StOk; done_o <= 1'b0;
      top_q <= '0; status_o <= StOk; result_o <= '0; depth_o <= '0;
    end else begin
      done_o <= 1'b0;
      case (st_q)
        SIdle: if (fire) st_q <= SRead;
        SRead: st_q <= SExec;
        SExec: begin
          st_q <= SIdle;
          done_o <= 1'b1;
          status_o <= err_q;
          result_o <= top_q;
          depth_o  <= 5'(dep_q);
          if (c_q.kind == KFinish) begin
            dep_q <= '0; err_q <= StOk; depth_o <= '0; top_q <= '0;
            if (err_q != StOk) result_o <= '0;
            else if (dep_q == '0) begin
              status_o <= StEmpty; result_o <= '0;
            end else begin
              status_o <= (dep_q == DW'(1)) ? StOk : StMulti;
              result_o <= mask_i ? {32'd0, fin_val[31:0]} : fin_val;
            end
          end else if (err_q == StOk) begin
            case (c_q.kind)
              KPush: begin
                if (dep_q >= DW'(StackDepth)) begin
                  err_q <= StFull; status_o <= StFull;
                end else begin
                  dep_q <= dep_q + DW'(1); top_q <= c_q.value;
                  result_o <= c_q.value; depth_o <= 5'(dep_q + DW'(1));
                end
              end
              KUnary: begin
                if (dep_q == '0) begin
                  err_q <= StFew; status_o <= StFew;
                end else begin
                  top_q <= unary_f(c_q.opcode, top_q);
                  result_o <= unary_f(c_q.opcode, top_q);
                end
              end
              KBinary, KDivide: begin
                if (dep_q < DW'(2)) begin
                  err_q <= StFew; status_o <= StFew;
                end else if (c_q.kind == KDivide && top_q == 64'd0) begin
                  err_q <= StDiv0; status_o <= StDiv0;
                end else if (c_q.kind == KDivide) begin
                  done_o <= 1'b0; st_q <= SDivW;
                end else if (c_q.opcode == OpMul) begin
                  done_o <= 1'b0; st_q <= SMul;
                end else begin
                  dep_q <= dep_q - DW'(1); top_q <= bres;
                  result_o <= bres; depth_o <= 5'(dep_q - DW'(1));
                end
              end
              default: ;
            endcase
          end
        end
        SMul: begin
          st_q <= SIdle; done_o <= 1'b1; status_o <= StOk;
          dep_q <= dep_q - DW'(1); top_q <= mul_q;
          result_o <= mul_q; depth_o <= 5'(dep_q - DW'(1));
        end
        SDivW: if (ddone) begin
          st_q <= SIdle; done_o <= 1'b1; status_o <= StOk;
          dep_q <= dep_q - DW'(1); top_q <= dres;
          result_o <= dres; depth_o <= 5'(dep_q - DW'(1));
        end
        default: st_q <= SIdle;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) c_q <= cmd_i;
  end
endmodule
`default_nettype wire

>>> rtl/core/rpn_stack_calculator.sv
// Top level of the RPN calculator: command front end, queue, execution back end,
// and the APB configuration register. Depends on rpn_pkg, rpn_front, rpn_back.
//
// Usage:
//  - Commands: drive mode_i/value_i/opcode_i with start high; a transaction
//    is taken at a rising edge where start is high and busy is low.
//  - A two-entry queue sits between the front end and the execution unit, so
//    busy only rises when both entries are waiting.
//  - Each command yields exactly one result, shown on status_o/result_o/depth_o
//    for one cycle with done_o high. The receiver cannot stall; results are
//    never held.
//  - Sequence: a command is popped in SIdle, the entry below top is read through
//    the stack memory's registered read port in SRead, and SExec raises done for
//    push, unary, finish and most binary ops; multiply adds SMul (partial
//    products over one extra register); divide and modulo wait in SDivW (one
//    quotient bit a cycle in the divider). The next command is taken only in SIdle.
//  - Configuration: APB register 0 (byte address 0) holds mask_to_32 in bit 0.
//    Write only while idle. pready is always high.
//  - Reset (rst_ni low, asynchronous) empties the stack, clears the error and
//    mask, and empties the queue. Stack memory contents are not cleared.
`default_nettype none
module rpn_stack_calculator
  import rpn_pkg::*;
#(
  parameter int unsigned StackDepth = StackDepthDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  mode_i,
  input  wire logic [63:0] value_i,
  input  wire logic [4:0]  opcode_i,
  output logic             done_o,
  output logic [2:0]       status_o,
  output logic [63:0]      result_o,
  output logic [4:0]       depth_o,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic        paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  logic mask_q;
  logic pop, avail;
  cmd_t cmd;

  assign pready = 1'b1;
  // single register at byte address 0; paddr is the one meaningful bit
  assign prdata = paddr ? 32'd0 : {31'd0, mask_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) mask_q <= 1'b0;
    else if (psel && penable && pwrite && !paddr) mask_q <= pwdata[0];
  end

  rpn_front u_front (
    .clk_i, .rst_ni, .start_i(start), .mode_i, .value_i, .opcode_i,
    .pop_i(pop), .busy_o(busy), .avail_o(avail), .cmd_o(cmd)
  );

  rpn_back #(.StackDepth(StackDepth)) u_back (
    .clk_i, .rst_ni, .avail_i(avail), .cmd_i(cmd), .mask_i(mask_q),
    .pop_o(pop), .done_o, .status_o, .result_o, .depth_o
  );
endmodule
`default_nettype wire

>>> rtl/core/rpn_checker.sv
// Port-level checker for the RPN calculator, bound to the top level.
// Depends on rpn_stack_calculator_assert.svh.
`default_nettype none
`include "rpn_stack_calculator_assert.svh"
module rpn_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        done_o,
  input wire logic [2:0]  status_o,
  input wire logic [4:0]  depth_o,
  input wire logic [63:0] result_o,
  input wire logic        pready
);
  `RPN_ASSERT_IMP(a_status_rng, clk_i, rst_ni, done_o, status_o <= 3'd5)
  `RPN_ASSERT_IMP(a_depth_rng, clk_i, rst_ni, done_o, depth_o <= 5'd16)
  `RPN_ASSERT_NXT(a_done_pulse, clk_i, rst_ni, done_o, !done_o)
  `RPN_ASSERT_IMP(a_empty_zero, clk_i, rst_ni, done_o && depth_o == 5'd0 && status_o == 3'd4,
                  result_o == 64'd0)
  `RPN_ASSERT_IMP(a_pready, clk_i, rst_ni, 1'b1, pready)
endmodule

bind rpn_stack_calculator rpn_checker u_chk (.*);
`default_nettype wire
